>>> hw/rtl/utf16_to_utf8_transcoder_core_defines.svh
// ----------------------------------------------------------------------------
// utf16 to utf8 transcoder assertion macros
// shared concurrent checks, clocked on i_clk and held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define U16U8_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every clock edge out of reset
`define U16U8_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) 1'b1 |-> (cond)) \
        else $error(msg);

`endif

>>> hw/rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// types, constants and utf8 encode helpers for the utf16 to utf8 transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UNIT_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int CP_W     = 22;
    localparam int LEN_W    = 3;
    localparam int MAX_LEN  = 4;

    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    // apb register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = PADDR_W - 2;
    localparam logic [REGIDX_W-1:0] REG_OUT_CAPACITY = '0;
    localparam logic [COUNT_W-1:0]  CAP_RESET        = 16'hffff;

    localparam logic [CP_W-1:0] CP_1BYTE_MAX = 22'h00007f;
    localparam logic [CP_W-1:0] CP_2BYTE_MAX = 22'h0007ff;
    localparam logic [CP_W-1:0] CP_3BYTE_MAX = 22'h00ffff;
    localparam logic [CP_W-1:0] CP_PAIR_BASE = 22'h010000;

    // one decoded code unit, ready for serialization
    typedef struct packed {
        logic [MAX_LEN-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]               len;
        logic                           term;
        logic [COUNT_W-1:0]             base;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic [LEN_W-1:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [LEN_W-1:0] len;
        if (cp <= CP_1BYTE_MAX) begin
            len = 3'd1;
        end else if (cp <= CP_2BYTE_MAX) begin
            len = 3'd2;
        end else if (cp <= CP_3BYTE_MAX) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic logic [MAX_LEN-1:0][BYTE_W-1:0] utf8_encode(
        input logic [CP_W-1:0]  cp,
        input logic [LEN_W-1:0] len
    );
        logic [MAX_LEN-1:0][BYTE_W-1:0] b;
        b = '0;
        case (len)
            3'd1: begin
                b[0] = cp[7:0];
            end
            3'd2: begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default: begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, pairs surrogates, checks capacity and queues byte jobs
// ----------------------------------------------------------------------------
module u16u8_front import u16u8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COUNT_W-1:0] i_out_capacity,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [UNIT_W-1:0]  i_code_unit,
    input  logic               i_end_of_string,
    input  t_qstat             i_qstat,
    output logic               o_push,
    output t_job               o_job
);

    logic               r_pending;
    logic [CP_W-1:0]    r_partial;
    logic [COUNT_W-1:0] r_bw;
    logic               r_full;

    logic               n_pending;
    logic [CP_W-1:0]    n_partial;
    logic [COUNT_W-1:0] n_bw;
    logic               n_full;

    logic               accept;
    logic               unit_zero;
    logic               is_sur;
    logic               is_low;
    logic               term;
    logic               have;
    logic [CP_W-1:0]    cp;
    logic [LEN_W-1:0]   cp_len;
    logic [LEN_W-1:0]   wr_len;
    logic [COUNT_W:0]   need;

    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign unit_zero  = (i_code_unit == '0);
    assign is_sur     = (i_code_unit[15:11] == 5'b11011);
    assign is_low     = (i_code_unit[15:10] == 6'b110111);
    assign term       = unit_zero || i_end_of_string;

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        n_bw      = r_bw;
        n_full    = r_full;
        have      = 1'b0;
        cp        = '0;
        wr_len    = '0;

        if (!unit_zero) begin
            if (!r_pending) begin
                if (!is_sur) begin
                    cp   = {6'b0, i_code_unit};
                    have = 1'b1;
                end else begin
                    // any unit of the surrogate range opens a pair
                    n_partial = {1'b0, i_code_unit[10:0], 10'b0} + CP_PAIR_BASE;
                    n_pending = 1'b1;
                end
            end else begin
                n_pending = 1'b0;
                if (is_low) begin
                    cp   = r_partial | {12'b0, i_code_unit[9:0]};
                    have = 1'b1;
                end
            end
        end

        cp_len = utf8_len(cp);
        need   = {1'b0, r_bw} + {{(COUNT_W+1-LEN_W){1'b0}}, cp_len} + 17'd1;

        if (have && !r_full) begin
            if (need > {1'b0, i_out_capacity}) begin
                n_full = 1'b1;
            end else begin
                wr_len = cp_len;
                n_bw   = r_bw + {{(COUNT_W-LEN_W){1'b0}}, cp_len};
            end
        end

        if (term) begin
            n_pending = 1'b0;
            n_partial = '0;
            n_bw      = '0;
            n_full    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_partial <= '0;
            r_bw      <= '0;
            r_full    <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_bw      <= n_bw;
            r_full    <= n_full;
        end
    end

    assign o_job.bytes = utf8_encode(cp, cp_len);
    assign o_job.len   = wr_len;
    assign o_job.term  = term;
    assign o_job.base  = r_bw;
    assign o_push      = accept && ((wr_len != '0) || term);

endmodule

>>> hw/rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// short job queue between the decode front and the byte serializer
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_core_defines.svh"

module u16u8_queue import u16u8_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_head,
    output t_qstat o_qstat
);

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `U16U8_ASSERT_IMPL(a_no_push_full, i_push, !o_qstat.full, "job pushed into full queue")
    `U16U8_ASSERT_IMPL(a_no_pop_empty, i_pop, !o_qstat.empty, "job popped from empty queue")
    `U16U8_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= QCNT_W'(Q_DEPTH), "queue count beyond depth")

endmodule

>>> hw/rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// walks the head job into the output register, one result per cycle while a job waits and the out port accepts
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_core_defines.svh"

module u16u8_back import u16u8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_head,
    input  t_qstat             i_qstat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_is_terminator,
    output logic [COUNT_W-1:0] o_byte_count,
    output logic               o_last
);

    logic [LEN_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_term;
    logic [COUNT_W-1:0] r_count;
    logic               r_last;

    logic               load;
    logic               in_bytes;
    logic [LEN_W-1:0]   idx_inc;
    logic [LEN_W-1:0]   cnt_ofs;
    logic [BYTE_W-1:0]  cur_byte;
    logic               cur_term;
    logic [COUNT_W-1:0] cur_count;
    logic               cur_last;

    assign load    = !i_qstat.empty && (!r_out_valid || i_out_ready);
    assign idx_inc = r_idx + 1'b1;

    always_comb begin
        in_bytes = (r_idx < i_head.len);
        if (in_bytes) begin
            cur_byte = i_head.bytes[r_idx[1:0]];
            cur_term = 1'b0;
            cnt_ofs  = idx_inc;
            cur_last = (idx_inc == i_head.len) && !i_head.term;
        end else begin
            // closing zero carries the string length
            cur_byte = '0;
            cur_term = 1'b1;
            cnt_ofs  = i_head.len;
            cur_last = 1'b1;
        end
        cur_count = i_head.base + {{(COUNT_W-LEN_W){1'b0}}, cnt_ofs};
    end

    assign o_pop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= cur_last ? '0 : idx_inc;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= cur_byte;
            r_term  <= cur_term;
            r_count <= cur_count;
            r_last  <= cur_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_byte;
    assign o_is_terminator = r_term;
    assign o_byte_count    = r_count;
    assign o_last          = r_last;

    `U16U8_ASSERT_IMPL(a_term_shape, r_out_valid && r_term, (r_byte == '0) && r_last,
        "terminator beat not a zero closing byte")
    `U16U8_ASSERT_ALWAYS(a_idx_bound, r_idx <= LEN_W'(MAX_LEN), "byte index past job")
    `U16U8_ASSERT_IMPL(a_pop_nonempty, o_pop, !i_qstat.empty, "pop of an empty job queue")

endmodule

>>> hw/rtl/utf16_to_utf8_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// utf16 code units in, utf8 bytes with a closing zero out, bounded capacity
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | i_code_unit, i_end_of_string
//  out     | output    | o_out_valid/i_out_ready | o_out_byte, o_is_terminator,
//          |           |                       | o_byte_count, o_last
//  apb     | input     | psel/penable/pready   | paddr, pwdata, prdata
//
//  a code unit is taken every cycle while the 4-entry job queue has room
//  each unit gives 0 to 5 beats, one beat per cycle on the out port while it is ready;
//  the first beat passes through the job queue and then the output register
//  synchronous active-low reset clears string state and sets out_capacity to 65535
//  out stalls back up into the queue and then the in port, never drop beats
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_core import u16u8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [UNIT_W-1:0]  i_code_unit,
    input  logic               i_end_of_string,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_out_byte,
    output logic               o_is_terminator,
    output logic [COUNT_W-1:0] o_byte_count,
    output logic               o_last
);

    logic [COUNT_W-1:0]  r_cap;
    logic [REGIDX_W-1:0] reg_idx;
    logic                cfg_wr;

    logic   push;
    logic   pop;
    t_job   job;
    t_job   head;
    t_qstat qstat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && (reg_idx == REG_OUT_CAPACITY)) begin
            r_cap <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_OUT_CAPACITY) ?
                    {{(PDATA_W-COUNT_W){1'b0}}, r_cap} : '0;

    u16u8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_out_capacity  (r_cap),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_job           (job)
    );

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_byte_count    (o_byte_count),
        .o_last          (o_last)
    );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16 to utf8 transcoder testbench
// drives code units with random gaps and output stalls, predicts the utf8
// beats with an own model of the string state and checks them in order
// ----------------------------------------------------------------------------

class utf8_scoreboard;

    localparam bit [15:0] SURR_FIRST = 16'hd800;
    localparam bit [15:0] LOW_FIRST  = 16'hdc00;
    localparam bit [15:0] SURR_LAST  = 16'hdfff;
    localparam bit [21:0] PAIR_BASE  = 22'h010000;

    typedef struct {
        bit [7:0]  data;
        bit        term;
        bit [15:0] count;
        bit        last;
    } t_utf8_beat;

    bit [15:0]  capacity;
    bit         pair_open;
    bit [21:0]  pair_value;
    bit [15:0]  written;
    bit         stopped;
    t_utf8_beat beat_q[$];
    int         errors;

    function new();
        capacity = 16'hffff;
        errors   = 0;
        clear_string();
    endfunction

    function void clear_string();
        pair_open  = 1'b0;
        pair_value = '0;
        written    = '0;
        stopped    = 1'b0;
    endfunction

    function void set_capacity(bit [15:0] value);
        capacity = value;
    endfunction

    function int pending();
        return beat_q.size();
    endfunction

    // expected beats for one accepted code unit
    function void note_unit(bit [15:0] unit, bit eos);
        bit [21:0]  cp;
        bit         have;
        int         len;
        int         n;
        bit [7:0]   enc[4];
        t_utf8_beat seq[5];
        cp   = '0;
        have = 1'b0;
        len  = 0;
        n    = 0;
        if (unit != 16'h0000) begin
            if (!pair_open) begin
                if (unit < SURR_FIRST || unit > SURR_LAST) begin
                    cp   = {6'd0, unit};
                    have = 1'b1;
                end else begin
                    // any surrogate opens a pair, a low one too
                    pair_value = (({6'd0, unit} - {6'd0, SURR_FIRST}) << 10) + PAIR_BASE;
                    pair_open  = 1'b1;
                end
            end else begin
                pair_open = 1'b0;
                if (unit >= LOW_FIRST && unit <= SURR_LAST) begin
                    cp   = pair_value | {6'd0, unit - LOW_FIRST};
                    have = 1'b1;
                end
            end
            if (have && !stopped) begin
                len = (cp <= 22'h7f) ? 1 : (cp <= 22'h7ff) ? 2 : (cp <= 22'hffff) ? 3 : 4;
                if (int'(written) + len + 1 > int'(capacity)) begin
                    stopped = 1'b1;
                end else begin
                    case (len)
                        1: begin
                            enc[0] = cp[7:0];
                        end
                        2: begin
                            enc[0] = 8'hc0 | 8'((cp >> 6) & 22'h1f);
                            enc[1] = 8'h80 | 8'(cp & 22'h3f);
                        end
                        3: begin
                            enc[0] = 8'he0 | 8'((cp >> 12) & 22'h0f);
                            enc[1] = 8'h80 | 8'((cp >> 6) & 22'h3f);
                            enc[2] = 8'h80 | 8'(cp & 22'h3f);
                        end
                        default: begin
                            enc[0] = 8'hf0 | 8'((cp >> 18) & 22'h07);
                            enc[1] = 8'h80 | 8'((cp >> 12) & 22'h3f);
                            enc[2] = 8'h80 | 8'((cp >> 6) & 22'h3f);
                            enc[3] = 8'h80 | 8'(cp & 22'h3f);
                        end
                    endcase
                    for (int i = 0; i < len; i++) begin
                        written = written + 16'd1;
                        seq[n]  = '{enc[i], 1'b0, written, 1'b0};
                        n++;
                    end
                end
            end
        end
        if (unit == 16'h0000 || eos) begin
            seq[n] = '{8'h00, 1'b1, written, 1'b0};
            n++;
            clear_string();
        end
        for (int i = 0; i < n; i++) begin
            seq[i].last = (i == n - 1);
            beat_q.push_back(seq[i]);
        end
    endfunction

    function void check_beat(logic [7:0] data, logic term, logic [15:0] count, logic last);
        t_utf8_beat want;
        if (beat_q.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected beat: byte %02h term %b count %0d last %b",
                         data, term, count, last);
            end
            return;
        end
        want = beat_q.pop_front();
        if (want.data !== data || want.term !== term || want.count !== count ||
            want.last !== last) begin
            errors++;
            if (errors <= 10) begin
                $display({"beat mismatch: expected byte %02h term %b count %0d last %b,",
                          " got byte %02h term %b count %0d last %b"},
                         want.data, want.term, want.count, want.last,
                         data, term, count, last);
            end
        end
    endfunction

endclass

module testbench;
    import u16u8_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 12;
    localparam int PHASE_UNITS = 22;
    localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_OUT_CAPACITY, 2'b00};

    logic               i_clk;
    logic               i_rst_n         = 1'b0;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [PADDR_W-1:0] paddr           = '0;
    logic [PDATA_W-1:0] pwdata          = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid      = 1'b0;
    logic               o_in_ready;
    logic [UNIT_W-1:0]  i_code_unit     = '0;
    logic               i_end_of_string = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready     = 1'b0;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_is_terminator;
    logic [COUNT_W-1:0] o_byte_count;
    logic               o_last;

    utf8_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int units_sent     = 0;
    int stuck_cycles   = 0;

    utf16_to_utf8_transcoder_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_is_terminator (o_is_terminator),
        .o_byte_count    (o_byte_count),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // both channels sampled at the edge, input beat first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_unit(i_code_unit, i_end_of_string);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_beat(o_out_byte, o_is_terminator, o_byte_count, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_code_unit     <= unit;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (!o_in_ready);
        units_sent++;
    endtask

    // hold the sender until every expected beat is out, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(value);
    endtask

    // one well-formed string mostly, with some broken pairs and raw noise
    task automatic send_string();
        int          n_cp;
        int          kind;
        logic [15:0] unit;
        if ($urandom_range(0, 9) == 0) begin
            wait_drained();
        end
        n_cp = $urandom_range(1, 8);
        repeat (n_cp) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                send_unit(16'($urandom_range(16'h0001, 16'h007f)), 1'b0);
            end else if (kind < 45) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07ff)), 1'b0);
            end else if (kind < 65) begin
                if ($urandom_range(0, 1) == 0) begin
                    unit = 16'($urandom_range(16'h0800, 16'hd7ff));
                end else begin
                    unit = 16'($urandom_range(16'he000, 16'hffff));
                end
                send_unit(unit, 1'b0);
            end else if (kind < 85) begin
                send_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
                send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
            end else if (kind < 90) begin
                send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
                send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'b0);
            end else if (kind < 95) begin
                send_unit(16'($urandom_range(16'hd800, 16'hdfff)), 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    unit = 16'($urandom_range(16'h0001, 16'hdbff));
                end else begin
                    unit = 16'($urandom_range(16'he000, 16'hffff));
                end
                send_unit(unit, 1'b0);
            end else begin
                send_unit(16'($urandom()), 1'b0);
            end
        end
        case ($urandom_range(0, 2))
            0: send_unit(16'h0000, 1'($urandom_range(0, 1)));
            1: send_unit(16'($urandom_range(16'h0001, 16'hffff)), 1'b1);
            default: send_unit(16'($urandom()), 1'b1);
        endcase
    endtask

    initial begin
        int target;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one, two and three byte lengths at their edges
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hffff, 1'b0);
        send_unit(16'h0001, 1'b0);
        // proper pairs, lone low pair, broken pair
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b0);
        // zero unit drops an open pair
        send_unit(16'hd83d, 1'b0);
        send_unit(16'h0000, 1'b0);
        // end flag on a real unit, on an open pair, on a zero unit
        send_unit(16'h00e9, 1'b1);
        send_unit(16'hd800, 1'b1);
        send_unit(16'h0000, 1'b1);

        // zero capacity: only the closing byte
        wait_drained();
        write_capacity(16'd0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b0);

        // output full sticks even when a shorter code point would fit
        wait_drained();
        write_capacity(16'd5);
        send_unit(16'h00e9, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0000, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0, 5:    write_capacity(16'hffff);
                1:       write_capacity(16'd1);
                4:       write_capacity(16'd2);
                2, 6:    write_capacity(16'($urandom_range(3, 12)));
                3:       write_capacity(16'($urandom_range(13, 80)));
                default: write_capacity(16'($urandom_range(100, 65534)));
            endcase
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            target = units_sent + PHASE_UNITS;
            while (units_sent < target) begin
                send_string();
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_transcoder_core.sv
dv/testbench.sv
